// ===== sv/ctfsm_pkg.sv =====
// shared types and constants of the connected transport controller
// used by ctfsm_front, ctfsm_back and connection_transport_fsm_unit; no dependencies
package ctfsm_pkg;

	// depth of the outgoing frame count and width of the counter that holds it
	localparam int QUEUE_DEPTH = 16;
	localparam int PEND_W      = $clog2(QUEUE_DEPTH + 1);

	// command queue between front and back
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);

	localparam int MAX_RES = 3;
	localparam int RES_IW  = 2;

	// input op codes
	localparam logic [3:0] OP_OPEN          = 4'd0;
	localparam logic [3:0] OP_CLOSE         = 4'd1;
	localparam logic [3:0] OP_TICK          = 4'd2;
	localparam logic [3:0] OP_QUEUE         = 4'd3;
	localparam logic [3:0] OP_RX_CONNECT    = 4'd4;
	localparam logic [3:0] OP_RX_DISCONNECT = 4'd5;
	localparam logic [3:0] OP_RX_DATA       = 4'd6;
	localparam logic [3:0] OP_RX_ACK        = 4'd7;
	localparam logic [3:0] OP_RX_NACK       = 4'd8;
	localparam logic [3:0] OP_RX_OTHER      = 4'd9;

	// result actions
	localparam logic [2:0] ACT_CONNECT    = 3'd0;
	localparam logic [2:0] ACT_DISCONNECT = 3'd1;
	localparam logic [2:0] ACT_ACK        = 3'd2;
	localparam logic [2:0] ACT_DATA       = 3'd3;
	localparam logic [2:0] ACT_DELIVER    = 3'd4;
	localparam logic [2:0] ACT_END        = 3'd5;
	localparam logic [2:0] ACT_POP        = 3'd6;
	localparam logic [2:0] ACT_REFUSED    = 3'd7;

	// link states
	localparam logic [1:0] MODE_CLOSED = 2'd0;
	localparam logic [1:0] MODE_IDLE   = 2'd1;
	localparam logic [1:0] MODE_ACKW   = 2'd2;

	// register indexes
	localparam logic [1:0] REG_IDLE_TO = 2'd0;
	localparam logic [1:0] REG_ACK_TO  = 2'd1;
	localparam logic [1:0] REG_MAX_REP = 2'd2;

	// classified event, as the front hands it to the back
	typedef enum logic [3:0] {
		K_OPEN,
		K_CLOSE,
		K_TICK,
		K_QUEUE,
		K_RX_CLOSE,
		K_RX_DATA,
		K_RX_ACK,
		K_RX_NACK,
		K_RX_OTHER
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] rx_seq;
		logic [1:0] rx_byte;
	} cmd_t;

	typedef struct packed {
		logic [15:0] idle_to;
		logic [15:0] ack_to;
		logic [3:0]  max_rep;
	} cfg_t;

	// handshake between front queue and back
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cq_out_t;

endpackage

// ===== sv/ctfsm_front.sv =====
// front of the transport controller: decodes input events and queues them
// depends on ctfsm_pkg
module ctfsm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [3:0]          op,
	input  logic [3:0]          rx_seq,
	input  logic [7:0]          rx_first_byte,
	output ctfsm_pkg::cq_out_t  head,
	input  logic                pop
);
	import ctfsm_pkg::*;

	cmd_t             fifo_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_AW:0]   cnt_q;

	cmd_t dec_cmd;
	logic dec_keep;
	logic push;
	logic do_pop;

	always_comb begin
		dec_cmd.rx_seq  = rx_seq;
		dec_cmd.rx_byte = rx_first_byte[1:0];
		dec_cmd.kind    = K_RX_OTHER;
		dec_keep        = 1'b1;
		unique case (op) inside
			OP_OPEN:                          dec_cmd.kind = K_OPEN;
			OP_CLOSE:                         dec_cmd.kind = K_CLOSE;
			OP_TICK:                          dec_cmd.kind = K_TICK;
			OP_QUEUE:                         dec_cmd.kind = K_QUEUE;
			OP_RX_CONNECT, OP_RX_DISCONNECT:  dec_cmd.kind = K_RX_CLOSE;
			OP_RX_DATA:                       dec_cmd.kind = K_RX_DATA;
			OP_RX_ACK:                        dec_cmd.kind = K_RX_ACK;
			OP_RX_NACK:                       dec_cmd.kind = K_RX_NACK;
			OP_RX_OTHER:                      dec_cmd.kind = K_RX_OTHER;
			// unused codes have no effect at all, so they are dropped here
			default:                          dec_keep     = 1'b0;
		endcase
	end

	assign in_ready   = (cnt_q != (CQ_AW+1)'(CQ_DEPTH));
	assign push       = in_valid && in_ready && dec_keep;
	assign do_pop     = pop && (cnt_q != '0);
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/ctfsm_back.sv =====
// back of the transport controller: link state machine and result sequencing
// depends on ctfsm_pkg; takes commands from ctfsm_front
module ctfsm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ctfsm_pkg::cfg_t    cfg,
	input  ctfsm_pkg::cq_out_t head,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [2:0]         action,
	output logic [3:0]         seq,
	output logic [1:0]         deliver_byte,
	output logic [1:0]         link_state,
	output logic               last
);
	import ctfsm_pkg::*;

	// link state
	logic [1:0]        mode_q;
	logic [3:0]        send_seq_q;
	logic [3:0]        recv_seq_q;
	logic [3:0]        rep_q;
	logic [15:0]       timer_q;
	logic              tack_q;
	logic [PEND_W-1:0] pend_q;

	// results of the item being delivered
	logic              busy_q;
	logic [RES_IW-1:0] cnt_q;
	logic [RES_IW-1:0] idx_q;
	logic [2:0]        act_q  [MAX_RES];
	logic [3:0]        seq_q  [MAX_RES];
	logic [1:0]        byte_q [MAX_RES];
	logic [1:0]        lstate_q;

	// next state and result list of the head command
	logic [1:0]        nm;
	logic [3:0]        nss;
	logic [3:0]        nrs;
	logic [3:0]        nrep;
	logic [15:0]       ntmr;
	logic              ntack;
	logic [PEND_W-1:0] npend;
	logic              do_close;
	logic [RES_IW-1:0] n;
	logic [2:0]        e_act  [MAX_RES];
	logic [3:0]        e_seq  [MAX_RES];
	logic [1:0]        e_byte [MAX_RES];
	logic              is_open;
	logic [15:0]       reload;
	logic              out_last;
	logic              go;

	always_comb begin
		nm       = mode_q;
		nss      = send_seq_q;
		nrs      = recv_seq_q;
		nrep     = rep_q;
		ntmr     = timer_q;
		ntack    = tack_q;
		npend    = pend_q;
		do_close = 1'b0;
		n        = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			e_act[i]  = ACT_REFUSED;
			e_seq[i]  = '0;
			e_byte[i] = '0;
		end
		is_open = (mode_q != MODE_CLOSED);
		reload  = tack_q ? cfg.ack_to : cfg.idle_to;

		unique case (head.cmd.kind)
			K_OPEN: begin
				if (is_open) begin
					e_act[n] = ACT_REFUSED;
					n        = n + 1'b1;
				end else begin
					e_act[n] = ACT_CONNECT;
					n        = n + 1'b1;
					nm       = MODE_IDLE;
					nss      = '0;
					nrs      = '0;
					nrep     = '0;
					ntack    = 1'b0;
					ntmr     = cfg.idle_to;
				end
			end
			K_CLOSE: begin
				if (is_open) begin
					do_close = 1'b1;
				end else begin
					e_act[n] = ACT_REFUSED;
					n        = n + 1'b1;
				end
			end
			K_TICK: begin
				if (is_open) begin
					if (timer_q <= 16'd1) begin
						if (mode_q == MODE_ACKW && rep_q < cfg.max_rep) begin
							nrep     = rep_q + 1'b1;
							e_act[n] = ACT_DATA;
							e_seq[n] = send_seq_q;
							n        = n + 1'b1;
							ntack    = 1'b1;
							ntmr     = cfg.ack_to;
						end else begin
							do_close = 1'b1;
						end
					end else begin
						ntmr = timer_q - 1'b1;
					end
				end
			end
			K_QUEUE: begin
				if (pend_q >= PEND_W'(QUEUE_DEPTH)) begin
					e_act[n] = ACT_REFUSED;
					n        = n + 1'b1;
				end else begin
					npend = pend_q + 1'b1;
					if (is_open) begin
						ntmr = reload;
					end
				end
			end
			default: begin
				// received frames; ignored while closed
				if (is_open) begin
					ntmr = reload;
					case (head.cmd.kind)
						K_RX_CLOSE: do_close = 1'b1;
						K_RX_DATA: begin
							if (head.cmd.rx_seq == recv_seq_q) begin
								e_act[n]  = ACT_DELIVER;
								e_byte[n] = head.cmd.rx_byte;
								n         = n + 1'b1;
								e_act[n]  = ACT_ACK;
								e_seq[n]  = recv_seq_q;
								n         = n + 1'b1;
								nrs       = recv_seq_q + 1'b1;
							end else if (head.cmd.rx_seq == recv_seq_q - 1'b1) begin
								// duplicate of the previous frame: ack it again
								e_act[n] = ACT_ACK;
								e_seq[n] = head.cmd.rx_seq;
								n        = n + 1'b1;
							end else begin
								do_close = 1'b1;
							end
						end
						K_RX_ACK: begin
							if (head.cmd.rx_seq != send_seq_q || mode_q != MODE_ACKW) begin
								do_close = 1'b1;
							end else begin
								e_act[n] = ACT_POP;
								n        = n + 1'b1;
								if (pend_q != '0) begin
									npend = pend_q - 1'b1;
								end
								nss   = send_seq_q + 1'b1;
								nm    = MODE_IDLE;
								ntack = 1'b0;
								ntmr  = cfg.idle_to;
							end
						end
						K_RX_NACK: begin
							if (head.cmd.rx_seq != send_seq_q || pend_q == '0 ||
							    rep_q >= cfg.max_rep || mode_q != MODE_ACKW) begin
								do_close = 1'b1;
							end else begin
								nrep     = rep_q + 1'b1;
								e_act[n] = ACT_DATA;
								e_seq[n] = send_seq_q;
								n        = n + 1'b1;
								ntack    = 1'b1;
								ntmr     = cfg.ack_to;
							end
						end
						default: ;
					endcase
				end
			end
		endcase

		// closing is always the final action of its branch
		if (do_close) begin
			e_act[n] = ACT_DISCONNECT;
			n        = n + 1'b1;
			e_act[n] = ACT_END;
			n        = n + 1'b1;
			nm       = MODE_CLOSED;
			ntmr     = '0;
			ntack    = 1'b0;
		end

		// idle with frames waiting: send the head frame at once
		if (nm == MODE_IDLE && npend != '0) begin
			nrep     = '0;
			e_act[n] = ACT_DATA;
			e_seq[n] = nss;
			n        = n + 1'b1;
			nm       = MODE_ACKW;
			ntack    = 1'b1;
			ntmr     = cfg.ack_to;
		end
	end

	assign out_last     = (idx_q == cnt_q - 1'b1);
	assign go           = head.valid && (!busy_q || (res_ready && out_last));
	assign pop          = go;
	assign res_valid    = busy_q;
	assign action       = act_q[idx_q];
	assign seq          = seq_q[idx_q];
	assign deliver_byte = byte_q[idx_q];
	assign link_state   = lstate_q;
	assign last         = out_last;

	always_ff @(posedge clk) begin
		if (go) begin
			for (int i = 0; i < MAX_RES; i++) begin
				act_q[i]  <= e_act[i];
				seq_q[i]  <= e_seq[i];
				byte_q[i] <= e_byte[i];
			end
			lstate_q <= nm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_CLOSED;
			send_seq_q <= '0;
			recv_seq_q <= '0;
			rep_q      <= '0;
			timer_q    <= '0;
			tack_q     <= 1'b0;
			pend_q     <= '0;
			busy_q     <= 1'b0;
			cnt_q      <= '0;
			idx_q      <= '0;
		end else begin
			if (go) begin
				mode_q     <= nm;
				send_seq_q <= nss;
				recv_seq_q <= nrs;
				rep_q      <= nrep;
				timer_q    <= ntmr;
				tack_q     <= ntack;
				pend_q     <= npend;
				busy_q     <= (n != '0);
				cnt_q      <= n;
				idx_q      <= '0;
			end else if (busy_q && res_ready) begin
				if (out_last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// the link never rests idle with frames waiting
	a_no_idle_pending: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> pend_q == '0)
		else $error("idle with queued frames");

	// a busy result buffer holds at least one result and points inside it
	a_busy_index: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0) && (idx_q < cnt_q))
		else $error("result index out of range");

	// the timer is loaded for an ack wait whenever the link waits for an ack
	a_ackw_timer: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_ACKW |-> tack_q)
		else $error("ack wait without ack timer");

	// a closed link keeps its timer cleared
	a_closed_timer: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_CLOSED |-> timer_q == '0 && !tack_q)
		else $error("timer running while closed");

endmodule

// ===== sv/connection_transport_fsm_unit.sv =====
// connected transport controller, top level: apb registers, front queue, back state machine
// depends on ctfsm_pkg, ctfsm_front, ctfsm_back
// path to the first result: the front command queue entry, then the back result registers
// throughput: one event per cycle into a 4-entry command queue while it has room; the back
// retires one event per cycle, or one per result (at most 3) as the result sink accepts them
// reset: link closed, counters and timer zero, timeouts 6 and 3 ticks, 3 repeats
module connection_transport_fsm_unit (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// events in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // op[3:0], rx_seq[7:4], rx_first_byte[15:8]
	// actions out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // action[2:0], seq[6:3], deliver_byte[8:7], link_state[10:9]
	output logic        m_tlast
);
	import ctfsm_pkg::*;

	cfg_t      cfg_q;
	cq_out_t   head;
	logic      pop;
	logic      wr_en;
	logic [2:0] action;
	logic [3:0] seq;
	logic [1:0] deliver_byte;
	logic [1:0] link_state;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_to <= 16'd6;
			cfg_q.ack_to  <= 16'd3;
			cfg_q.max_rep <= 4'd3;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_IDLE_TO: cfg_q.idle_to <= pwdata[15:0];
				REG_ACK_TO:  cfg_q.ack_to  <= pwdata[15:0];
				REG_MAX_REP: cfg_q.max_rep <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_IDLE_TO: prdata = {16'd0, cfg_q.idle_to};
			REG_ACK_TO:  prdata = {16'd0, cfg_q.ack_to};
			REG_MAX_REP: prdata = {28'd0, cfg_q.max_rep};
			default:     prdata = '0;
		endcase
	end

	ctfsm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.op            (s_tdata[3:0]),
		.rx_seq        (s_tdata[7:4]),
		.rx_first_byte (s_tdata[15:8]),
		.head          (head),
		.pop           (pop)
	);

	ctfsm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.pop          (pop),
		.res_valid    (m_tvalid),
		.res_ready    (m_tready),
		.action       (action),
		.seq          (seq),
		.deliver_byte (deliver_byte),
		.link_state   (link_state),
		.last         (m_tlast)
	);

	assign m_tdata = {5'd0, link_state, deliver_byte, seq, action};

endmodule

// ===== tb/connection_transport_fsm_unit_test.sv =====
// self-checking testbench for the connected transport controller top level
// depends on ctfsm_pkg and connection_transport_fsm_unit; drives events, apb and sink stalls
`timescale 1ns / 1ps

module connection_transport_fsm_unit_test;
	import ctfsm_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int PHASE_EVENTS   = 60;

	// op codes the block ignores
	localparam logic [3:0] OP_UNUSED_LO = 4'd10;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;

	typedef struct packed {
		logic [2:0] action;
		logic [3:0] seq;
		logic [1:0] dbyte;
		logic [1:0] state;
		logic       last;
	} outcome_t;

	typedef struct packed {
		logic [3:0] op;
		logic [3:0] rseq;
		logic [7:0] rbyte;
		logic       pin;
		logic [2:0] act;
		logic [1:0] st;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // op[3:0], rx_seq[7:4], rx_first_byte[15:8]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // action[2:0], seq[6:3], deliver_byte[8:7], link_state[10:9]
	logic        m_tlast;

	connection_transport_fsm_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #1 clk = ~clk;

	// predicted link state and registers
	cfg_t        link_cfg;
	logic [1:0]  link_mode;
	logic [3:0]  tx_seq;
	logic [3:0]  rx_expect;
	logic [3:0]  repeats;
	logic [15:0] countdown;
	bit          countdown_ack;
	int unsigned queued_frames;

	outcome_t step_actions[$];
	outcome_t awaited_actions[$];

	int  mismatches = 0;
	int  events_done = 0;
	int  quiet_cycles = 0;
	bit  calm = 1'b0;
	bit  timed_out = 1'b0;
	int  ready_hold = 0;

	task automatic flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endtask

	task automatic post_action(logic [2:0] a, logic [3:0] s, logic [1:0] b);
		outcome_t o;
		o = '0;
		o.action = a;
		o.seq = s;
		o.dbyte = b;
		step_actions.push_back(o);
	endtask

	task automatic rearm_timer();
		countdown = countdown_ack ? link_cfg.ack_to : link_cfg.idle_to;
	endtask

	task automatic drop_link();
		post_action(ACT_DISCONNECT, 4'd0, 2'd0);
		post_action(ACT_END, 4'd0, 2'd0);
		link_mode = MODE_CLOSED;
		countdown = '0;
		countdown_ack = 1'b0;
	endtask

	task automatic resend_head();
		repeats = repeats + 4'd1;
		post_action(ACT_DATA, tx_seq, 2'd0);
		countdown_ack = 1'b1;
		countdown = link_cfg.ack_to;
	endtask

	// works out the actions of one event into step_actions
	task automatic advance_link(logic [3:0] op, logic [3:0] rseq, logic [7:0] rbyte);
		bit is_open;
		is_open = link_mode != MODE_CLOSED;
		step_actions.delete();
		case (op)
			OP_OPEN: begin
				if (is_open) begin
					post_action(ACT_REFUSED, 4'd0, 2'd0);
				end else begin
					post_action(ACT_CONNECT, 4'd0, 2'd0);
					link_mode = MODE_IDLE;
					tx_seq = '0;
					rx_expect = '0;
					repeats = '0;
					countdown_ack = 1'b0;
					rearm_timer();
				end
			end
			OP_CLOSE: begin
				if (is_open)
					drop_link();
				else
					post_action(ACT_REFUSED, 4'd0, 2'd0);
			end
			OP_TICK: begin
				if (is_open) begin
					if (countdown <= 16'd1) begin
						if (link_mode == MODE_ACKW && repeats < link_cfg.max_rep)
							resend_head();
						else
							drop_link();
					end else begin
						countdown = countdown - 16'd1;
					end
				end
			end
			OP_QUEUE: begin
				if (queued_frames >= QUEUE_DEPTH) begin
					post_action(ACT_REFUSED, 4'd0, 2'd0);
				end else begin
					queued_frames++;
					if (is_open)
						rearm_timer();
				end
			end
			OP_RX_CONNECT, OP_RX_DISCONNECT, OP_RX_DATA, OP_RX_ACK, OP_RX_NACK,
			OP_RX_OTHER: begin
				if (is_open) begin
					rearm_timer();
					case (op)
						OP_RX_CONNECT, OP_RX_DISCONNECT: drop_link();
						OP_RX_DATA: begin
							if (rseq == rx_expect) begin
								post_action(ACT_DELIVER, 4'd0, rbyte[1:0]);
								post_action(ACT_ACK, rx_expect, 2'd0);
								rx_expect = rx_expect + 4'd1;
							end else if (rseq == 4'(rx_expect - 4'd1)) begin
								// repeated frame, ack it again
								post_action(ACT_ACK, rseq, 2'd0);
							end else begin
								drop_link();
							end
						end
						OP_RX_ACK: begin
							if (rseq != tx_seq || link_mode != MODE_ACKW) begin
								drop_link();
							end else begin
								post_action(ACT_POP, 4'd0, 2'd0);
								if (queued_frames > 0)
									queued_frames--;
								tx_seq = tx_seq + 4'd1;
								link_mode = MODE_IDLE;
								countdown_ack = 1'b0;
								rearm_timer();
							end
						end
						OP_RX_NACK: begin
							if (rseq != tx_seq || queued_frames == 0 ||
								repeats >= link_cfg.max_rep || link_mode != MODE_ACKW)
								drop_link();
							else
								resend_head();
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		// idle with frames waiting starts the next transmission
		if (link_mode == MODE_IDLE && queued_frames > 0) begin
			repeats = '0;
			post_action(ACT_DATA, tx_seq, 2'd0);
			link_mode = MODE_ACKW;
			countdown_ack = 1'b1;
			countdown = link_cfg.ack_to;
		end
		foreach (step_actions[k]) begin
			step_actions[k].state = link_mode;
			step_actions[k].last = (k == step_actions.size() - 1);
		end
	endtask

	task automatic send_event(logic [3:0] op, logic [3:0] rseq, logic [7:0] rbyte,
		bit pin = 1'b0, logic [2:0] pin_act = ACT_CONNECT,
		logic [1:0] pin_state = MODE_CLOSED);
		s_tvalid <= 1'b1;
		s_tdata <= {rbyte, rseq, op};
		do @(posedge clk); while (!s_tready);
		events_done++;
		advance_link(op, rseq, rbyte);
		if (pin && step_actions.size() != 0) begin
			step_actions[0].action = pin_act;
			step_actions[0].state = pin_state;
		end
		foreach (step_actions[k])
			awaited_actions.push_back(step_actions[k]);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= 16'($urandom);
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// hold off the sender until every action is back and the block has gone quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (awaited_actions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(logic [1:0] idx, bit wr, logic [31:0] wval,
		output logic [31:0] rval);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wval;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rval = prdata;
		if (wr) begin
			case (idx)
				REG_IDLE_TO: link_cfg.idle_to = wval[15:0];
				REG_ACK_TO:  link_cfg.ack_to = wval[15:0];
				REG_MAX_REP: link_cfg.max_rep = wval[3:0];
				default: ;
			endcase
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_config(cfg_t c);
		logic [31:0] rd;
		logic [31:0] want;
		logic [31:0] mask;
		logic [1:0]  idx;
		apb_access(REG_IDLE_TO, 1'b1, {16'd0, c.idle_to}, rd);
		apb_access(REG_ACK_TO, 1'b1, {16'd0, c.ack_to}, rd);
		apb_access(REG_MAX_REP, 1'b1, {28'd0, c.max_rep}, rd);
		for (int i = 0; i < 3; i++) begin
			idx = 2'(i);
			apb_access(idx, 1'b0, 32'd0, rd);
			case (idx)
				REG_IDLE_TO: begin want = {16'd0, link_cfg.idle_to}; mask = 32'hffff; end
				REG_ACK_TO:  begin want = {16'd0, link_cfg.ack_to}; mask = 32'hffff; end
				default:     begin want = {28'd0, link_cfg.max_rep}; mask = 32'hf; end
			endcase
			if ((rd & mask) != want)
				flag_mismatch($sformatf("register %0d read %0h, expected %0h", i,
					rd & mask, want));
		end
	endtask

	// random events, mostly well-formed exchanges steered by the predicted state
	task automatic roam_link(int target);
		int start;
		int pick;
		logic [3:0] r4;
		logic [7:0] r8;
		start = events_done;
		while (events_done - start < target) begin
			pick = $urandom_range(0, 99);
			r4 = 4'($urandom);
			r8 = 8'($urandom);
			case (link_mode)
				MODE_CLOSED: begin
					if (pick < 60)
						send_event(OP_OPEN, r4, r8);
					else if (pick < 70)
						send_event(OP_QUEUE, r4, r8);
					else if (pick < 74)
						repeat (QUEUE_DEPTH + 1) send_event(OP_QUEUE, 4'($urandom), 8'($urandom));
					else if (pick < 80)
						send_event(OP_CLOSE, r4, r8);
					else
						send_event(4'($urandom), r4, r8);
				end
				MODE_IDLE: begin
					if (pick < 35)
						send_event(OP_RX_DATA, rx_expect, r8);
					else if (pick < 40)
						send_event(OP_RX_DATA, 4'(rx_expect - 4'd1), r8);
					else if (pick < 55)
						send_event(OP_QUEUE, r4, r8);
					else if (pick < 70)
						repeat ($urandom_range(1, 8)) send_event(OP_TICK, 4'($urandom), 8'($urandom));
					else if (pick < 75)
						send_event(OP_RX_OTHER, r4, r8);
					else if (pick < 78)
						send_event(OP_OPEN, r4, r8);
					else if (pick < 81)
						send_event(OP_CLOSE, r4, r8);
					else if (pick < 84)
						send_event(pick[0] ? OP_RX_CONNECT : OP_RX_DISCONNECT, r4, r8);
					else if (pick < 88)
						send_event(OP_RX_ACK, r4, r8);
					else if (pick < 91)
						send_event(OP_RX_NACK, r4, r8);
					else if (pick < 95)
						send_event(OP_RX_DATA, r4, r8);
					else
						send_event(4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), r4, r8);
				end
				default: begin
					if (pick < 35)
						send_event(OP_RX_ACK, tx_seq, r8);
					else if (pick < 45)
						send_event(OP_RX_NACK, tx_seq, r8);
					else if (pick < 65)
						repeat ($urandom_range(1, 8)) send_event(OP_TICK, 4'($urandom), 8'($urandom));
					else if (pick < 73)
						send_event(OP_RX_DATA, rx_expect, r8);
					else if (pick < 78)
						send_event(OP_QUEUE, r4, r8);
					else if (pick < 81)
						send_event(OP_RX_ACK, 4'(tx_seq + 4'($urandom_range(1, 15))), r8);
					else if (pick < 84)
						send_event(OP_RX_NACK, 4'(tx_seq + 4'($urandom_range(1, 15))), r8);
					else if (pick < 87)
						send_event(OP_RX_OTHER, r4, r8);
					else if (pick < 90)
						send_event(OP_CLOSE, r4, r8);
					else if (pick < 93)
						send_event(OP_OPEN, r4, r8);
					else
						send_event(4'($urandom), r4, r8);
				end
			endcase
		end
	endtask

	// sink stalls in bursts, none once calm
	always @(posedge clk) begin
		if (calm) begin
			m_tready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 2) == 0) begin
			m_tready <= 1'b0;
			ready_hold <= $urandom_range(0, 13);
		end else begin
			m_tready <= 1'b1;
			ready_hold <= $urandom_range(0, 20);
		end
	end

	// compare each accepted result transaction with the oldest prediction
	always @(posedge clk) begin
		outcome_t seen;
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen.action = m_tdata[2:0];
			seen.seq = m_tdata[6:3];
			seen.dbyte = m_tdata[8:7];
			seen.state = m_tdata[10:9];
			seen.last = m_tlast;
			if (awaited_actions.size() == 0) begin
				flag_mismatch($sformatf("unexpected act %0d seq %0d byte %0d state %0d last %0d",
					seen.action, seen.seq, seen.dbyte, seen.state, seen.last));
			end else begin
				want = awaited_actions.pop_front();
				if (seen != want)
					flag_mismatch($sformatf(
						"expected act %0d seq %0d byte %0d state %0d last %0d, got %0d %0d %0d %0d %0d",
						want.action, want.seq, want.dbyte, want.state, want.last,
						seen.action, seen.seq, seen.dbyte, seen.state, seen.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		stim_row_t opening_rows [24];
		cfg_t phase_cfg [6];
		opening_rows = '{
			'{OP_TICK,          4'd0,  8'h00, 1'b0, ACT_CONNECT,    MODE_CLOSED},
			'{OP_RX_DATA,       4'd0,  8'h00, 1'b0, ACT_CONNECT,    MODE_CLOSED},
			'{OP_CLOSE,         4'd0,  8'h00, 1'b1, ACT_REFUSED,    MODE_CLOSED},
			'{OP_OPEN,          4'd0,  8'h00, 1'b1, ACT_CONNECT,    MODE_IDLE},
			'{OP_OPEN,          4'hf,  8'hff, 1'b1, ACT_REFUSED,    MODE_IDLE},
			'{OP_RX_DATA,       4'd0,  8'hff, 1'b1, ACT_DELIVER,    MODE_IDLE},
			'{OP_RX_DATA,       4'd0,  8'h00, 1'b1, ACT_ACK,        MODE_IDLE},
			'{OP_RX_OTHER,      4'hf,  8'hff, 1'b0, ACT_CONNECT,    MODE_CLOSED},
			'{OP_QUEUE,         4'd0,  8'h00, 1'b1, ACT_DATA,       MODE_ACKW},
			'{OP_RX_NACK,       4'd0,  8'h00, 1'b1, ACT_DATA,       MODE_ACKW},
			'{OP_TICK,          4'd0,  8'h00, 1'b0, ACT_CONNECT,    MODE_CLOSED},
			'{OP_TICK,          4'd0,  8'h00, 1'b0, ACT_CONNECT,    MODE_CLOSED},
			'{OP_TICK,          4'd0,  8'h00, 1'b0, ACT_CONNECT,    MODE_CLOSED},
			'{OP_RX_ACK,        4'd0,  8'h00, 1'b1, ACT_POP,        MODE_IDLE},
			'{OP_RX_DATA,       4'hf,  8'haa, 1'b1, ACT_DISCONNECT, MODE_CLOSED},
			'{OP_QUEUE,         4'd0,  8'h00, 1'b0, ACT_CONNECT,    MODE_CLOSED},
			'{OP_OPEN,          4'd0,  8'h00, 1'b1, ACT_CONNECT,    MODE_ACKW},
			'{OP_RX_ACK,        4'd5,  8'h55, 1'b1, ACT_DISCONNECT, MODE_CLOSED},
			'{OP_UNUSED_LO,     4'd0,  8'h00, 1'b0, ACT_CONNECT,    MODE_CLOSED},
			'{OP_UNUSED_HI,     4'hf,  8'hff, 1'b0, ACT_CONNECT,    MODE_CLOSED},
			'{OP_OPEN,          4'd0,  8'h00, 1'b1, ACT_CONNECT,    MODE_ACKW},
			'{OP_RX_CONNECT,    4'd0,  8'h00, 1'b1, ACT_DISCONNECT, MODE_CLOSED},
			'{OP_OPEN,          4'd0,  8'h00, 1'b1, ACT_CONNECT,    MODE_ACKW},
			'{OP_RX_DISCONNECT, 4'd0,  8'h00, 1'b1, ACT_DISCONNECT, MODE_CLOSED}
		};
		phase_cfg[0] = '{idle_to: 16'd1, ack_to: 16'd1, max_rep: 4'd0};
		phase_cfg[1] = '{idle_to: 16'd0, ack_to: 16'd0, max_rep: 4'd15};
		phase_cfg[2] = '{idle_to: 16'hffff, ack_to: 16'hffff, max_rep: 4'd15};
		phase_cfg[3] = '{idle_to: 16'd2, ack_to: 16'd1, max_rep: 4'd1};
		phase_cfg[4] = '{idle_to: 16'($urandom_range(1, 12)), ack_to: 16'($urandom_range(1, 6)),
			max_rep: 4'($urandom)};
		phase_cfg[5] = '{idle_to: 16'd6, ack_to: 16'd3, max_rep: 4'd3};

		link_cfg = '{idle_to: 16'd6, ack_to: 16'd3, max_rep: 4'd3};
		link_mode = MODE_CLOSED;
		tx_seq = '0;
		rx_expect = '0;
		repeats = '0;
		countdown = '0;
		countdown_ack = 1'b0;
		queued_frames = 0;

		fork
			begin
				repeat (8) @(posedge clk);
				arst_n <= 1'b1;
				@(posedge clk);
				foreach (opening_rows[i])
					send_event(opening_rows[i].op, opening_rows[i].rseq, opening_rows[i].rbyte,
						opening_rows[i].pin, opening_rows[i].act, opening_rows[i].st);
				settle();
				foreach (phase_cfg[p]) begin
					calm = (p == 5);
					load_config(phase_cfg[p]);
					roam_link(PHASE_EVENTS);
					settle();
				end
			end
			begin
				wait (quiet_cycles >= WATCHDOG_LIMIT);
				timed_out = 1'b1;
				$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			end
		join_any

		if (awaited_actions.size() != 0)
			$display("%0d expected results never arrived", awaited_actions.size());
		if (!timed_out && mismatches == 0 && awaited_actions.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
